[hw/rtl/wsdf_pkg.sv]
// Package for the WebSocket frame deframer: length widths, header constants,
// the parse phase encoding and the event kind type.
// No dependencies.
package wsdf_pkg;

  // Width of the length field as received, and the width that is kept.
  localparam int unsigned LengthBits = 64;
  localparam int unsigned LenW       = (LengthBits >= 63) ? 63 : LengthBits;
  localparam int unsigned FrameLenW  = 63;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KeyW  = 32;

  // Seven-bit length codes and the control frame limit.
  localparam logic [6:0] CtrlMaxLen = 7'd125;
  localparam logic [6:0] Len16Code  = 7'd126;

  localparam logic [3:0] ExtBytes16 = 4'd2;
  localparam logic [3:0] ExtBytes64 = 4'd8;
  localparam logic [2:0] KeyBytes   = 3'd4;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXT     = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  typedef enum logic {
    EV_HEADER  = 1'b0,
    EV_PAYLOAD = 1'b1
  } event_kind_e;

endpackage

[hw/rtl/wsdf_if.sv]
// Channel interfaces of the deframer: the received byte stream and the
// event stream. Depends on wsdf_pkg for field widths.
interface wsdf_byte_if;
  logic                          valid;
  logic                          ready;
  logic [wsdf_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wsdf_event_if;
  logic                             valid;
  logic                             ready;
  logic                             event_kind;
  logic [3:0]                       opcode;
  logic                             final_fragment;
  logic                             was_masked;
  logic [wsdf_pkg::FrameLenW-1:0]   frame_length;
  logic                             control_too_long;
  logic [wsdf_pkg::ByteW-1:0]       data_byte;
  logic                             last_of_frame;

  modport source (
    output valid, output event_kind, output opcode, output final_fragment,
    output was_masked, output frame_length, output control_too_long,
    output data_byte, output last_of_frame, input ready
  );
  modport sink (
    input valid, input event_kind, input opcode, input final_fragment,
    input was_masked, input frame_length, input control_too_long,
    input data_byte, input last_of_frame, output ready
  );
endinterface

[hw/rtl/websocket_frame_deframer.sv]
// WebSocket receive deframer: one received byte per request, one event out
// per header or payload byte. Depends on wsdf_pkg and wsdf_if.
//
// The block takes one byte per clock cycle for as long as the downstream side
// keeps up: a byte is accepted whenever the result register is empty or is
// being taken in the same cycle, and its event (if any) appears in the result
// register on the next cycle. Header bytes, extended length bytes and key
// bytes give no event; the header event comes with the byte that completes
// the header, and each payload byte gives one unmasked byte event. Lengths
// are kept to 63 bits; the top bit of an 8-byte length is dropped. There is
// no start-up sweep: the block is ready straight after reset.
module websocket_frame_deframer (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsdf_byte_if.sink    rx_i,
  wsdf_event_if.source ev_o
);
  import wsdf_pkg::*;

  // Parser state.
  phase_e              phase_q, phase_d;
  logic                fin_q, fin_d;
  logic                mask_q, mask_d;
  logic [3:0]          op_q, op_d;
  logic [3:0]          ext_left_q, ext_left_d;
  logic [LenW-1:0]     acc_q, acc_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [2:0]          key_left_q, key_left_d;
  logic [LenW-1:0]     pl_q, pl_d;
  logic [1:0]          idx_q, idx_d;

  // Result register.
  logic                out_valid_q;
  event_kind_e         kind_q;
  logic [3:0]          ev_op_q;
  logic                ev_fin_q;
  logic                ev_mask_q;
  logic [FrameLenW-1:0] ev_len_q;
  logic                ev_ctrl_long_q;
  logic [ByteW-1:0]    ev_data_q;
  logic                ev_last_q;

  logic                in_fire;
  logic [ByteW-1:0]    b;
  logic                emit;
  event_kind_e         emit_kind;
  logic [ByteW-1:0]    emit_data;
  logic                emit_last;
  logic                len_done;
  logic                hdr_event;
  logic [KeyW-1:0]     key_sh;

  assign rx_i.ready = !out_valid_q || ev_o.ready;
  assign in_fire    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign key_sh     = key_q >> {(2'd3 - idx_q), 3'b000};

  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    mask_d     = mask_q;
    op_d       = op_q;
    ext_left_d = ext_left_q;
    acc_d      = acc_q;
    key_d      = key_q;
    key_left_d = key_left_q;
    pl_d       = pl_q;
    idx_d      = idx_q;
    emit       = 1'b0;
    emit_kind  = EV_HEADER;
    emit_data  = '0;
    emit_last  = 1'b0;
    len_done   = 1'b0;
    hdr_event  = 1'b0;

    case (phase_q)
      PH_HDR0: begin
        fin_d   = b[7];
        mask_d  = 1'b0;
        op_d    = b[3:0];
        key_d   = '0;
        acc_d   = '0;
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d = b[7];
        if (b[6:0] <= CtrlMaxLen) begin
          acc_d    = LenW'(b[6:0]);
          len_done = 1'b1;
        end else begin
          acc_d      = '0;
          ext_left_d = (b[6:0] == Len16Code) ? ExtBytes16 : ExtBytes64;
          phase_d    = PH_EXT;
        end
      end
      PH_EXT: begin
        acc_d      = {acc_q[LenW-ByteW-1:0], b};
        ext_left_d = ext_left_q - 4'd1;
        len_done   = (ext_left_d == 4'd0);
      end
      PH_KEY: begin
        key_d      = {key_q[KeyW-ByteW-1:0], b};
        key_left_d = key_left_q - 3'd1;
        hdr_event  = (key_left_d == 3'd0);
      end
      PH_PAYLOAD: begin
        emit      = 1'b1;
        emit_kind = EV_PAYLOAD;
        emit_data = b ^ key_sh[ByteW-1:0];
        emit_last = (pl_q <= LenW'(1));
        idx_d     = idx_q + 2'd1;
        if (emit_last) begin
          pl_d    = '0;
          phase_d = PH_HDR0;
        end else begin
          pl_d    = pl_q - LenW'(1);
        end
      end
      default: begin
        phase_d = PH_HDR0;
      end
    endcase

    // The length is complete: a masked frame still needs its key.
    if (len_done) begin
      if (mask_d) begin
        phase_d    = PH_KEY;
        key_left_d = KeyBytes;
      end else begin
        hdr_event  = 1'b1;
      end
    end

    if (hdr_event) begin
      emit      = 1'b1;
      emit_kind = EV_HEADER;
      emit_last = (acc_d == '0);
      pl_d      = acc_d;
      idx_d     = 2'd0;
      phase_d   = emit_last ? PH_HDR0 : PH_PAYLOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      fin_q      <= 1'b0;
      mask_q     <= 1'b0;
      op_q       <= '0;
      ext_left_q <= '0;
      acc_q      <= '0;
      key_q      <= '0;
      key_left_q <= '0;
      pl_q       <= '0;
      idx_q      <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      mask_q     <= mask_d;
      op_q       <= op_d;
      ext_left_q <= ext_left_d;
      acc_q      <= acc_d;
      key_q      <= key_d;
      key_left_q <= key_left_d;
      pl_q       <= pl_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (ev_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload fields carry the header values as they stand after this byte.
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      kind_q         <= emit_kind;
      ev_op_q        <= op_d;
      ev_fin_q       <= fin_d;
      ev_mask_q      <= mask_d;
      ev_len_q       <= FrameLenW'(acc_d);
      ev_ctrl_long_q <= op_d[3] && (acc_d > LenW'(CtrlMaxLen));
      ev_data_q      <= emit_data;
      ev_last_q      <= emit_last;
    end
  end

  assign ev_o.valid            = out_valid_q;
  assign ev_o.event_kind       = kind_q;
  assign ev_o.opcode           = ev_op_q;
  assign ev_o.final_fragment   = ev_fin_q;
  assign ev_o.was_masked       = ev_mask_q;
  assign ev_o.frame_length     = ev_len_q;
  assign ev_o.control_too_long = ev_ctrl_long_q;
  assign ev_o.data_byte        = ev_data_q;
  assign ev_o.last_of_frame    = ev_last_q;

  // A first header byte never gives an event.
  a_hdr0_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_HDR0 |=> !out_valid_q)
    else $error("event produced for a first header byte");

  // Every byte accepted in the payload phase gives a payload event.
  a_payload_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q == PH_PAYLOAD |=> out_valid_q && kind_q == EV_PAYLOAD)
    else $error("payload byte produced no payload event");

  // The payload phase is only entered with bytes still to come.
  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> pl_q != '0)
    else $error("payload phase with no bytes left");

  // Key bytes are only collected for masked frames.
  a_key_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_KEY |-> mask_q)
    else $error("key phase in an unmasked frame");

  // A header event closes the frame exactly when the frame is empty.
  a_hdr_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == EV_HEADER |-> ev_last_q == (ev_len_q == '0))
    else $error("header last flag disagrees with frame length");

endmodule
